@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and disabled
// while the synchronous active-low reset is applied.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ket_pkg.sv @@
// ----------------------------------------------------------------------------
// ket_pkg
// Field widths, request and status codes, sequencer states and the control
// bundle shared by the keyed entry table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ket_pkg;

  localparam int KIND_W     = 2;
  localparam int PORT_KEY_W = 32;
  localparam int PORT_VAL_W = 32;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 6;
  localparam int COUNT_W    = 7;

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_FINISH
  } ket_state_t;

  typedef struct packed {
    logic clear_we;  // clearing pass writes an empty key this cycle
    logic rd_en;     // scan issues a read this cycle
    logic cmp_vld;   // read data of a scanned entry is on the memory outputs
    logic finish;    // scan complete, decide and report
  } ket_ctl_t;

endpackage

`default_nettype wire

@@ hdl/ket_store.sv @@
// ----------------------------------------------------------------------------
// ket_store
// Key and value memories: one shared write address, one shared read address,
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ket_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int KW    = 32,
  parameter int VW    = 32
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [KW-1:0] rd_key,
  output logic [VW-1:0] rd_val,
  input  logic          wr_key_en,
  input  logic          wr_val_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [KW-1:0] wr_key,
  input  logic [VW-1:0] wr_val
);
  import ket_pkg::*;

  logic [KW-1:0] key_mem [DEPTH];
  logic [VW-1:0] val_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_val_en) begin
      val_mem[wr_addr] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_val <= val_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/ket_seq.sv @@
// ----------------------------------------------------------------------------
// ket_seq
// Request sequencer: clearing pass after reset, then one scan of all entries
// per request, followed by a compare drain state and a finish state.
// ----------------------------------------------------------------------------
`default_nettype none

module ket_seq #(
  parameter int ENTRIES = 64,
  parameter int AW      = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  output logic             busy,
  output logic [AW-1:0]    idx,
  output logic [AW-1:0]    cmp_idx,
  output ket_pkg::ket_ctl_t ctl
);
  import ket_pkg::*;

  ket_state_t    state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] cmp_idx_r;
  logic          cmp_vld_r;
  logic          idx_last;

  assign idx_last = (idx_r == AW'(ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      cmp_vld_r <= ctl.rd_en;
    end
  end

  // Entry index of the read now returning from memory.
  always_ff @(posedge clk) begin
    cmp_idx_r <= idx_r;
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    ctl.clear_we = 1'b0;
    ctl.rd_en    = 1'b0;
    ctl.cmp_vld  = cmp_vld_r;
    ctl.finish   = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ctl.clear_we = 1'b1;
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.rd_en = 1'b1;
        if (idx_last) begin
          state_nxt = S_LAST;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_LAST: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        ctl.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy        = (state_r != S_IDLE);
  assign idx         = idx_r;
  assign cmp_idx     = cmp_idx_r;

endmodule

`default_nettype wire

@@ hdl/keyed_entry_table_core.sv @@
// ----------------------------------------------------------------------------
// keyed_entry_table_core
// Key/value table of ENTRIES slots searched by linear scan. A command is
// taken at a clock edge with start high and busy low; it is a lookup, an
// insert or a remove, and a key of zero is refused. Each command scans every
// slot of the key memory, one slot per cycle through its single read port,
// then passes through a last-compare state and a write-back and decision
// state, with busy high throughout. The result appears in the cycle after
// the decision on the out_ ports for exactly one cycle, marked by out_valid;
// the receiver cannot stall it, and busy is already low in that cycle so the
// next command may be taken. After reset the block runs a clearing pass that
// writes every key slot empty; busy is high during it.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_entry_table_core #(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [ket_pkg::KIND_W-1:0]     in_kind,
  input  logic [ket_pkg::PORT_KEY_W-1:0] in_key,
  input  logic [ket_pkg::PORT_VAL_W-1:0] in_value,
  output logic                           out_valid,
  output logic [ket_pkg::STATUS_W-1:0]   out_status,
  output logic [ket_pkg::PORT_VAL_W-1:0] out_value_out,
  output logic [ket_pkg::SLOT_W-1:0]     out_slot,
  output logic [ket_pkg::COUNT_W-1:0]    out_used_count
);
  import ket_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int KW = (KEY_BITS < PORT_KEY_W) ? KEY_BITS : PORT_KEY_W;
  localparam int VW = (VALUE_BITS < PORT_VAL_W) ? VALUE_BITS : PORT_VAL_W;
  localparam int OW = $clog2(ENTRIES + 1);

  logic          accept;
  ket_ctl_t      ctl;
  logic [AW-1:0] idx;
  logic [AW-1:0] cmp_idx;

  // Request held for the whole scan.
  logic [KIND_W-1:0] req_kind_r;
  logic [KW-1:0]     req_key_r;
  logic [VW-1:0]     req_val_r;

  // Memory read data and write port.
  logic [KW-1:0] rd_key;
  logic [VW-1:0] rd_val;
  logic          wr_key_en;
  logic          wr_val_en;
  logic [AW-1:0] wr_addr;
  logic [KW-1:0] wr_key;

  // Scan accumulators: first match and first empty slot.
  logic          hit_r, hit_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;
  logic [VW-1:0] hit_val_r, hit_val_nxt;
  logic          free_r, free_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt;
  logic [OW-1:0] occ_r, occ_nxt;

  // Result registers.
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [PORT_VAL_W-1:0] value_out_r, value_out_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [COUNT_W-1:0]    used_r;

  logic req_ins;
  logic req_rem;
  logic req_zero;
  logic match;
  logic empty_seen;
  logic rem_we;
  logic ins_we;

  assign accept = start & ~busy;

  ket_seq #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .busy    (busy),
    .idx     (idx),
    .cmp_idx (cmp_idx),
    .ctl     (ctl)
  );

  ket_store #(
    .DEPTH (ENTRIES),
    .AW    (AW),
    .KW    (KW),
    .VW    (VW)
  ) u_store (
    .clk       (clk),
    .rd_en     (ctl.rd_en),
    .rd_addr   (idx),
    .rd_key    (rd_key),
    .rd_val    (rd_val),
    .wr_key_en (wr_key_en),
    .wr_val_en (wr_val_en),
    .wr_addr   (wr_addr),
    .wr_key    (wr_key),
    .wr_val    (req_val_r)
  );

  // Capture the transaction; only the low key and value bits are kept.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind_r <= in_kind;
      req_key_r  <= in_key[KW-1:0];
      req_val_r  <= in_value[VW-1:0];
    end
  end

  // Any kind other than insert or remove acts as a lookup.
  assign req_ins  = (req_kind_r == KIND_INSERT);
  assign req_rem  = (req_kind_r == KIND_REMOVE);
  assign req_zero = (req_key_r == '0);

  // A zero key never matches, since empty slots hold zero.
  assign match      = ctl.cmp_vld && (rd_key != '0) && (rd_key == req_key_r);
  assign empty_seen = ctl.cmp_vld && (rd_key == '0);

  // Remove clears each matching slot as its read returns; the scan has
  // already moved on to the next slot, so read and write never collide.
  assign rem_we = match && req_rem;
  assign ins_we = ctl.finish && req_ins && !req_zero && !hit_r && free_r;

  always_comb begin
    wr_key_en = ctl.clear_we | rem_we | ins_we;
    wr_val_en = ins_we;
    wr_key    = ins_we ? req_key_r : '0;
    if (ctl.clear_we) begin
      wr_addr = idx;
    end else if (rem_we) begin
      wr_addr = cmp_idx;
    end else begin
      wr_addr = free_idx_r;
    end
  end

  always_comb begin
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_val_nxt  = hit_val_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    occ_nxt      = occ_r;
    if (accept) begin
      hit_nxt  = 1'b0;
      free_nxt = 1'b0;
    end
    // Keep the lowest matching slot and its value.
    if (match && !hit_r) begin
      hit_nxt     = 1'b1;
      hit_idx_nxt = cmp_idx;
      hit_val_nxt = rd_val;
    end
    // Keep the lowest empty slot for an insert.
    if (empty_seen && !free_r) begin
      free_nxt     = 1'b1;
      free_idx_nxt = cmp_idx;
    end
    // Drop one from the count per cleared slot, never below zero.
    if (rem_we && (occ_r != '0)) begin
      occ_nxt = occ_r - 1'b1;
    end
    if (ins_we) begin
      occ_nxt = occ_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      occ_r  <= '0;
    end else begin
      hit_r  <= hit_nxt;
      free_r <= free_nxt;
      occ_r  <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    hit_val_r  <= hit_val_nxt;
    free_idx_r <= free_idx_nxt;
  end

  // Decide the outcome once the scan has seen every slot.
  always_comb begin
    status_nxt    = ST_OK;
    value_out_nxt = '0;
    slot_nxt      = '0;
    if (req_zero) begin
      status_nxt = ST_ZERO_KEY;
    end else if (req_ins) begin
      if (hit_r) begin
        status_nxt = ST_PRESENT;
        slot_nxt   = SLOT_W'(hit_idx_r);
      end else if (free_r) begin
        slot_nxt = SLOT_W'(free_idx_r);
      end else begin
        status_nxt = ST_FULL;
      end
    end else if (req_rem) begin
      if (hit_r) begin
        slot_nxt = SLOT_W'(hit_idx_r);
      end else begin
        status_nxt = ST_NOT_FOUND;
      end
    end else begin
      if (hit_r) begin
        value_out_nxt = PORT_VAL_W'(hit_val_r);
        slot_nxt      = SLOT_W'(hit_idx_r);
      end else begin
        status_nxt = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.finish;
    end
  end

  // Hold the result fields until the next transaction finishes.
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      status_r    <= status_nxt;
      value_out_r <= value_out_nxt;
      slot_r      <= slot_nxt;
      used_r      <= COUNT_W'(occ_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_value_out  = value_out_r;
  assign out_slot       = slot_r;
  assign out_used_count = used_r;

endmodule

`default_nettype wire

@@ hdl/ket_checker.sv @@
// ----------------------------------------------------------------------------
// ket_checker
// Port-level checks of the keyed entry table, attached to the top level by
// the bind at the end of this file.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ket_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           out_valid,
  input wire logic [ket_pkg::STATUS_W-1:0]   out_status,
  input wire logic [ket_pkg::PORT_VAL_W-1:0] out_value_out
);
  import ket_pkg::*;

  // A result comes only after the transaction has released the sequencer.
  `ASSERT_SAME(a_result_idle, clk, rst_n, out_valid, !busy, "result while busy")

  // A taken transaction occupies the block from the next cycle on.
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept without busy")

  // A result strobe lasts one cycle.
  `ASSERT_NEXT(a_one_strobe, clk, rst_n, out_valid, !out_valid, "result longer than one cycle")

  // Only a successful lookup carries a value; checked here for failed requests.
  `ASSERT_SAME(a_value_zero, clk, rst_n, out_valid && (out_status != ST_OK),
    out_value_out == '0, "value on a failed request")

endmodule

bind keyed_entry_table_core ket_checker u_ket_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_value_out (out_value_out)
);

`default_nettype wire

@@ tb/tb_keyed_entry_table_core.sv @@
// ----------------------------------------------------------------------------
// tb_keyed_entry_table_core
// Self-checking bench for the keyed entry table. It opens with a short table
// of directed commands: empty-table misses, zero keys, the spare request
// code, all-ones and all-zero keys and values, and a duplicate insert. It then
// sends about six hundred random commands that fill the table past full,
// mix every request kind and drain it again, under three start-idle profiles.
// The local table model, or a typed row's own answer, predicts each command;
// each result strobe is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_keyed_entry_table_core;
  import ket_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int POOL_SIZE   = 128;
  localparam int RAND_CMDS   = 600;
  localparam int ROUND_LEN   = 200;  // one idle profile per round
  localparam int DIR_ROWS    = 23;

  // The block answers the unused request code as a lookup.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [PORT_VAL_W-1:0] value_out;
    logic [SLOT_W-1:0]     slot;
    logic [COUNT_W-1:0]    used_count;
  } table_resp_t;

  // One directed command; typed rows carry their answer, the rest go to the
  // table model.
  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [PORT_KEY_W-1:0] key;
    logic [PORT_VAL_W-1:0] value;
    logic                  typed;
    table_resp_t           resp;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [KIND_W-1:0]     in_kind;
  logic [PORT_KEY_W-1:0] in_key;
  logic [PORT_VAL_W-1:0] in_value;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [PORT_VAL_W-1:0] out_value_out;
  logic [SLOT_W-1:0]     out_slot;
  logic [COUNT_W-1:0]    out_used_count;

  // Local copy of the table contents
  logic [PORT_KEY_W-1:0] tbl_key [TABLE_DEPTH];
  logic [PORT_VAL_W-1:0] tbl_val [TABLE_DEPTH];
  int                    tbl_used;
  int                    tbl_peak;

  table_resp_t           pending_responses [$];
  logic [PORT_KEY_W-1:0] key_pool [POOL_SIZE];

  int cmds_issued;
  int mismatch_count;
  int status_seen [5];

  dir_row_t dir_rows [DIR_ROWS] = '{
    // empty table misses
    '{KIND_LOOKUP, 32'h1, 32'h0, 1'b1, '{ST_NOT_FOUND, 32'h0, 6'd0, 7'd0}},
    '{KIND_REMOVE, 32'h1, 32'h0, 1'b1, '{ST_NOT_FOUND, 32'h0, 6'd0, 7'd0}},
    // zero key refused for every kind
    '{KIND_INSERT, 32'h0, 32'hFFFF_FFFF, 1'b1, '{ST_ZERO_KEY, 32'h0, 6'd0, 7'd0}},
    '{KIND_LOOKUP, 32'h0, 32'h0, 1'b1, '{ST_ZERO_KEY, 32'h0, 6'd0, 7'd0}},
    '{KIND_SPARE,  32'h0, 32'h0, 1'b1, '{ST_ZERO_KEY, 32'h0, 6'd0, 7'd0}},
    '{KIND_REMOVE, 32'h0, 32'h0, 1'b1, '{ST_ZERO_KEY, 32'h0, 6'd0, 7'd0}},
    // extremes of key and value
    '{KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h0, 6'd0, 7'd1}},
    '{KIND_INSERT, 32'h1, 32'h0, 1'b1, '{ST_OK, 32'h0, 6'd1, 7'd2}},
    // duplicate insert reports the holding slot
    '{KIND_INSERT, 32'hFFFF_FFFF, 32'h5, 1'b1, '{ST_PRESENT, 32'h0, 6'd0, 7'd2}},
    '{KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b1,
      '{ST_OK, 32'hFFFF_FFFF, 6'd0, 7'd2}},
    '{KIND_SPARE,  32'h1, 32'h0, 1'b1, '{ST_OK, 32'h0, 6'd1, 7'd2}},
    '{KIND_REMOVE, 32'hFFFF_FFFF, 32'h0, 1'b1, '{ST_OK, 32'h0, 6'd0, 7'd1}},
    '{KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b1, '{ST_NOT_FOUND, 32'h0, 6'd0, 7'd1}},
    // freed slot is the lowest empty one
    '{KIND_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 1'b1, '{ST_OK, 32'h0, 6'd0, 7'd2}},
    '{KIND_INSERT, 32'h7FFF_FFFE, 32'h5A5A_5A5A, 1'b0, '0},
    '{KIND_LOOKUP, 32'h8000_0000, 32'h0, 1'b0, '0},
    '{KIND_REMOVE, 32'h1, 32'h0, 1'b0, '0},
    '{KIND_INSERT, 32'h1, 32'hFFFF_FFFF, 1'b0, '0},
    '{KIND_LOOKUP, 32'h1, 32'h0, 1'b0, '0},
    '{KIND_REMOVE, 32'h2, 32'h0, 1'b0, '0},
    '{KIND_SPARE,  32'h7FFF_FFFE, 32'h0, 1'b0, '0},
    '{KIND_REMOVE, 32'h8000_0000, 32'h0, 1'b0, '0},
    '{KIND_INSERT, 32'h8000_0000, 32'h1, 1'b0, '0}
  };

  keyed_entry_table_core #(
    .ENTRIES    (TABLE_DEPTH),
    .KEY_BITS   (PORT_KEY_W),
    .VALUE_BITS (PORT_VAL_W)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_value_out  (out_value_out),
    .out_slot       (out_slot),
    .out_used_count (out_used_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one command to the local table and return the answer the block
  // owes for it.
  function automatic table_resp_t apply_table_cmd(input logic [KIND_W-1:0] kind,
                                                  input logic [PORT_KEY_W-1:0] key,
                                                  input logic [PORT_VAL_W-1:0] value);
    table_resp_t r;
    int          hit;
    int          free_idx;
    r        = '0;
    r.status = ST_OK;
    hit      = -1;
    free_idx = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_key[i] != '0 && tbl_key[i] == key && hit < 0) hit = i;
      if (tbl_key[i] == '0 && free_idx < 0) free_idx = i;
    end
    if (key == '0) begin
      r.status = ST_ZERO_KEY;
    end else if (kind == KIND_INSERT) begin
      if (hit >= 0) begin
        r.status = ST_PRESENT;
        r.slot   = SLOT_W'(hit);
      end else if (free_idx < 0) begin
        r.status = ST_FULL;
      end else begin
        tbl_key[free_idx] = key;
        tbl_val[free_idx] = value;
        tbl_used++;
        r.slot = SLOT_W'(free_idx);
      end
    end else if (kind == KIND_REMOVE) begin
      if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        r.slot = SLOT_W'(hit);
        // clear every copy, lowest slot reported
        for (int i = hit; i < TABLE_DEPTH; i++) begin
          if (tbl_key[i] == key) begin
            tbl_key[i] = '0;
            tbl_val[i] = '0;
            if (tbl_used > 0) tbl_used--;
          end
        end
      end
    end else begin
      // lookup and the spare code
      if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        r.value_out = tbl_val[hit];
        r.slot      = SLOT_W'(hit);
      end
    end
    if (tbl_used > tbl_peak) tbl_peak = tbl_used;
    r.used_count = COUNT_W'(tbl_used);
    return r;
  endfunction

  // Present one command from the falling edge on; raise start at random per
  // cycle until a transaction is taken. Start is left as is on return so the
  // next command owns the only update of it in that step.
  task automatic issue_cmd(input logic [KIND_W-1:0] kind,
                           input logic [PORT_KEY_W-1:0] key,
                           input logic [PORT_VAL_W-1:0] value,
                           input logic typed,
                           input table_resp_t typed_resp,
                           input int idle_pct);
    table_resp_t predicted;
    bit          taken;
    taken    = 1'b0;
    in_kind  <= kind;
    in_key   <= key;
    in_value <= value;
    while (!taken) begin
      start <= ($urandom_range(0, 99) >= idle_pct);
      @(posedge clk);
      taken = start && !busy;
      @(negedge clk);
    end
    predicted = apply_table_cmd(kind, key, value);
    pending_responses.push_back(typed ? typed_resp : predicted);
    cmds_issued++;
  endtask

  // Drop start and hold until every transaction has been answered.
  task automatic wait_table_idle;
    start <= 1'b0;
    do @(negedge clk); while (pending_responses.size() != 0);
  endtask

  // Result checking: every strobe must match the oldest prediction.
  always @(posedge clk) begin
    table_resp_t want;
    if (rst_n && out_valid) begin
      if (out_status < 5) status_seen[out_status]++;
      if (pending_responses.size() == 0) begin
        $error("unexpected result: status %0d slot %0d", out_status, out_slot);
        mismatch_count++;
      end else begin
        want = pending_responses.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_value_out !== want.value_out) begin
          $error("value_out: expected %h, got %h", want.value_out, out_value_out);
          mismatch_count++;
        end
        if (out_slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_slot);
          mismatch_count++;
        end
        if (out_used_count !== want.used_count) begin
          $error("used_count: expected %0d, got %0d", want.used_count, out_used_count);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [KIND_W-1:0]     kind;
    logic [PORT_KEY_W-1:0] key;
    logic [PORT_KEY_W-1:0] cand;
    bit                    dup;
    int                    pos;
    int                    roll;
    int                    idle_pct;
    int                    base;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_kind        = KIND_LOOKUP;
    in_key         = '0;
    in_value       = '0;
    cmds_issued    = 0;
    mismatch_count = 0;
    tbl_used       = 0;
    tbl_peak       = 0;
    idle_pct       = 22;
    base           = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_key[i] = '0;
      tbl_val[i] = '0;
    end

    // Build a pool of distinct nonzero keys, twice the table depth so that
    // sequential inserts from it overrun the table.
    for (int i = 0; i < POOL_SIZE; i++) begin
      do begin
        cand = $urandom;
        dup  = 1'b0;
        for (int j = 0; j < i; j++) if (key_pool[j] == cand) dup = 1'b1;
      end while (cand == '0 || dup);
      key_pool[i] = cand;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table; the clearing pass after reset is covered by busy.
    foreach (dir_rows[i])
      issue_cmd(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].value,
                dir_rows[i].typed, dir_rows[i].resp, 22);

    // Random rounds: fill mostly with inserts of pool keys, mix all kinds, then
    // drain. Each round runs under its own start-idle profile.
    for (int n = 0; n < RAND_CMDS; n++) begin
      pos = n % ROUND_LEN;
      if (pos == 0) begin
        wait_table_idle();
        idle_pct = (n < ROUND_LEN) ? 22 : (n < 2 * ROUND_LEN) ? 72 : 0;
        base     = $urandom_range(0, POOL_SIZE - 1);
      end
      roll = $urandom_range(0, 99);
      if (pos < 80) begin
        kind = (roll < 90) ? KIND_INSERT : KIND_LOOKUP;
        key  = key_pool[(base + pos) % POOL_SIZE];
      end else if (pos < 140) begin
        kind = (roll < 30) ? KIND_LOOKUP :
               (roll < 60) ? KIND_INSERT :
               (roll < 90) ? KIND_REMOVE : KIND_SPARE;
        roll = $urandom_range(0, 99);
        key  = (roll < 84) ? key_pool[$urandom_range(0, POOL_SIZE - 1)] :
               (roll < 95) ? PORT_KEY_W'($urandom) : '0;
      end else begin
        kind = (roll < 70) ? KIND_REMOVE : (roll < 90) ? KIND_LOOKUP : KIND_INSERT;
        key  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      issue_cmd(kind, key, PORT_VAL_W'($urandom), 1'b0, '0, idle_pct);
    end

    // Let the last transaction finish, then allow a full scan for strays.
    wait_table_idle();
    repeat (2 * (TABLE_DEPTH + 4)) @(negedge clk);

    $display("Ran %0d commands through fill, mixed and drain rounds; peak occupancy %0d of %0d",
             cmds_issued, tbl_peak, TABLE_DEPTH);
    $display("Results: ok %0d, not found %0d, present %0d, full %0d, zero key %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #(2_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ keyed_entry_table_core.f @@
+incdir+hdl
hdl/ket_pkg.sv
hdl/ket_store.sv
hdl/ket_seq.sv
hdl/keyed_entry_table_core.sv
hdl/ket_checker.sv
tb/tb_keyed_entry_table_core.sv
